[rtl/led_pkg.sv]
`default_nettype none

package led_pkg;

    // Default number of stored columns.
    localparam int LED_MAX_COLUMNS = 64;

    // Field widths of the beats on either side and of the configuration register.
    localparam int LED_BYTE_W   = 8;
    localparam int LED_ACTION_W = 3;
    localparam int LED_COUNT_W  = 7;
    localparam int LED_CFG_W    = 7;

    // Reset value of the line width register.
    localparam logic [LED_CFG_W-1:0] LED_WIDTH_RESET = 7'd40;

    // Keyboard codes handled by the discipline.
    localparam logic [LED_BYTE_W-1:0] BYTE_EOF        = 8'd4;
    localparam logic [LED_BYTE_W-1:0] BYTE_KILL       = 8'd21;
    localparam logic [LED_BYTE_W-1:0] BYTE_WERASE     = 8'd23;
    localparam logic [LED_BYTE_W-1:0] BYTE_SPACE      = 8'd32;
    localparam logic [LED_BYTE_W-1:0] BYTE_LAST_PRINT = 8'd126;
    localparam logic [LED_BYTE_W-1:0] BYTE_ERASE      = 8'd127;

    // Result action codes.
    localparam logic [LED_ACTION_W-1:0] ACT_ECHO   = 3'd0;
    localparam logic [LED_ACTION_W-1:0] ACT_WRAP   = 3'd1;
    localparam logic [LED_ACTION_W-1:0] ACT_RUBOUT = 3'd2;
    localparam logic [LED_ACTION_W-1:0] ACT_BELL   = 3'd3;
    localparam logic [LED_ACTION_W-1:0] ACT_EXIT   = 3'd4;

    // Configuration register index.
    localparam logic REG_LINE_WIDTH = 1'b0;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_WORD,
        ST_DONE
    } t_state;

    // Shift command that every cell of the column stack obeys.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_op;

endpackage

`default_nettype wire

[rtl/led_cell.sv]
`default_nettype none

module led_cell
    import led_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_shift_op i_op,
    input  wire logic      i_from_prev,
    input  wire logic      i_from_next,
    output logic           o_bit
);

    logic r_bit;
    logic n_bit;

    // A push takes the neighbour nearer the top, a pop the one further down.
    always_comb begin
        n_bit = r_bit;
        if (i_op.push) begin
            n_bit = i_from_prev;
        end else if (i_op.pop) begin
            n_bit = i_from_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

[rtl/line_edit_discipline_top.sv]
`default_nettype none
// Line editing discipline for a raw keyboard byte stream.
// Input beats arrive on s_axis (tdata holds one keyboard byte). Each beat gives
// at most one result beat on m_axis: echo, newline then echo, rub out with a
// column count, bell or exit. Erase, kill and word erase with nothing to rub
// out give no result. After exit every input beat is taken and dropped.
// The line width register sits at APB address 0 and is to be written only while
// the block is idle, which the block itself does not enforce; pready is always high.
// The per-column space flags live in a row of cells working as a stack, the
// newest column at the front. A printable byte pushes, an erase pops.
// The result beat of an accepted byte enters the output register in the next
// cycle. A word erase scans one column per cycle, first the trailing spaces,
// then the word, at most MAX_COLUMNS columns; a step at the boundary issues
// the result once the output register is free, and no input is taken meanwhile.
// Other bytes accept one beat per cycle while results are taken.
// A stalled receiver holds the result in the output register; the next input
// beat is taken in the cycle that the pending result leaves.
// Synchronous reset empties the line, clears exit and sets the width to 40.

module line_edit_discipline_top
    import led_pkg::*;
#(
    parameter int MAX_COLUMNS = LED_MAX_COLUMNS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream: tdata[7:0] in_byte.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // Result stream: tdata[2:0] action, [10:3] echo_char, [17:11] rubout_count,
    // [23:18] zero.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = $clog2(MAX_COLUMNS + 1);
    localparam int CW = (LW > LED_CFG_W) ? LW : LED_CFG_W;

    // Configuration register.
    logic [LED_CFG_W-1:0] r_line_width;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);
    assign prdata    = (paddr[2] == REG_LINE_WIDTH)
                       ? {{(32 - LED_CFG_W){1'b0}}, r_line_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LED_WIDTH_RESET;
        end else if (cfg_write) begin
            r_line_width <= pwdata[LED_CFG_W-1:0];
        end
    end

    // Effective width, clamped to one and to the number of cells.
    logic [CW-1:0] width_ext;
    logic [CW-1:0] eff_width;

    always_comb begin
        width_ext = CW'(r_line_width);
        if (r_line_width == '0) begin
            eff_width = CW'(1);
        end else if (width_ext > CW'(MAX_COLUMNS)) begin
            eff_width = CW'(MAX_COLUMNS);
        end else begin
            eff_width = width_ext;
        end
    end

    // Column stack: cell 0 holds the newest column.
    t_shift_op            shift_op;
    logic                 new_bit;
    logic [MAX_COLUMNS:0] chain;
    logic                 top_is_space;

    assign chain[MAX_COLUMNS] = 1'b0;

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cells
        logic from_prev;
        if (g == 0) begin : g_head
            assign from_prev = new_bit;
        end else begin : g_body
            assign from_prev = chain[g-1];
        end
        led_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (shift_op),
            .i_from_prev (from_prev),
            .i_from_next (chain[g+1]),
            .o_bit       (chain[g])
        );
    end

    assign top_is_space = chain[0];

    // Controller registers.
    t_state               r_state, n_state;
    logic [LW-1:0]        r_len, n_len;
    logic [LW-1:0]        r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [LED_ACTION_W-1:0] r_out_action, n_out_action;
    logic [LED_BYTE_W-1:0]   r_out_echo, n_out_echo;
    logic [LED_COUNT_W-1:0]  r_out_count, n_out_count;

    logic          accept;
    logic          out_free;
    logic          printable;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] cnt_ext;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_DONE) || ((r_state == ST_IDLE) && out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign printable     = (s_axis_tdata >= BYTE_SPACE) && (s_axis_tdata <= BYTE_LAST_PRINT);
    assign new_bit       = (s_axis_tdata == BYTE_SPACE);
    assign len_ext       = CW'(r_len);
    assign cnt_ext       = CW'(r_cnt);

    // Next state, line length, stack shifts and result beat.
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_action = r_out_action;
        n_out_echo   = r_out_echo;
        n_out_count  = r_out_count;
        shift_op     = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_axis_tdata == BYTE_EOF) && (r_len == '0)) begin
                        n_out_valid  = 1'b1;
                        n_out_action = ACT_EXIT;
                        n_out_echo   = '0;
                        n_out_count  = '0;
                        n_state      = ST_DONE;
                    end else if (s_axis_tdata == BYTE_ERASE) begin
                        if (r_len != '0) begin
                            shift_op.pop = 1'b1;
                            n_len        = r_len - LW'(1);
                            n_out_valid  = 1'b1;
                            n_out_action = ACT_RUBOUT;
                            n_out_echo   = '0;
                            n_out_count  = LED_COUNT_W'(1);
                        end
                    end else if (s_axis_tdata == BYTE_KILL) begin
                        if (r_len != '0) begin
                            n_len        = '0;
                            n_out_valid  = 1'b1;
                            n_out_action = ACT_RUBOUT;
                            n_out_echo   = '0;
                            n_out_count  = len_ext[LED_COUNT_W-1:0];
                        end
                    end else if (s_axis_tdata == BYTE_WERASE) begin
                        n_cnt   = '0;
                        n_state = ST_SKIP;
                    end else if (printable) begin
                        shift_op.push = 1'b1;
                        n_out_valid   = 1'b1;
                        n_out_echo    = s_axis_tdata;
                        n_out_count   = '0;
                        if (len_ext >= eff_width) begin
                            n_len        = LW'(1);
                            n_out_action = ACT_WRAP;
                        end else begin
                            n_len        = r_len + LW'(1);
                            n_out_action = ACT_ECHO;
                        end
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_action = ACT_BELL;
                        n_out_echo   = '0;
                        n_out_count  = '0;
                    end
                end
            end
            // Word erase, first pass: drop trailing spaces.
            ST_SKIP: begin
                if ((r_len != '0) && top_is_space) begin
                    shift_op.pop = 1'b1;
                    n_len        = r_len - LW'(1);
                    n_cnt        = r_cnt + LW'(1);
                end else begin
                    n_state = ST_WORD;
                end
            end
            // Word erase, second pass: drop the word, then report the count if it is not zero.
            ST_WORD: begin
                if ((r_len != '0) && !top_is_space) begin
                    shift_op.pop = 1'b1;
                    n_len        = r_len - LW'(1);
                    n_cnt        = r_cnt + LW'(1);
                end else if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_action = ACT_RUBOUT;
                    n_out_echo   = '0;
                    n_out_count  = cnt_ext[LED_COUNT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            ST_DONE: begin
                n_state = ST_DONE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_action <= n_out_action;
        r_out_echo   <= n_out_echo;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_count, r_out_echo, r_out_action};

    // The line never holds more columns than there are cells.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_COLUMNS))
        else $error("line length beyond the column stack");

    // The stack never pushes and pops in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(shift_op.push && shift_op.pop))
        else $error("push and pop together");

    // A pop only happens on a non-empty line and shortens it by one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_op.pop |-> (r_len != '0) && (n_len == r_len - LW'(1)))
        else $error("pop on an empty line");

    // No input is taken while a word erase scans.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SKIP) || (r_state == ST_WORD)) |-> !s_axis_tready)
        else $error("input taken during a word erase scan");

    // After exit no new result beat appears.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_out_valid || m_axis_tready)) |=> !r_out_valid)
        else $error("result issued after exit");

endmodule

`default_nettype wire

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import led_pkg::*;

    // Cycles without any beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Worst case word erase scan plus a margin, used before register writes and at the end.
    localparam int SETTLE_CYCLES  = LED_MAX_COLUMNS + 6;

    // Fixed opening sequence of edit keys, run at the reset line width.
    localparam logic [7:0] EDIT_KEYS [24] = '{
        BYTE_ERASE, BYTE_KILL, BYTE_WERASE, 8'h00, 8'h1F, 8'h80, 8'hFF,
        BYTE_SPACE, BYTE_LAST_PRINT, "a", "b", BYTE_SPACE, BYTE_SPACE,
        BYTE_WERASE, BYTE_EOF, BYTE_WERASE, "x", "y", BYTE_ERASE, "z",
        BYTE_KILL, "q", BYTE_ERASE, 8'h0A
    };

    typedef struct packed {
        logic [LED_ACTION_W-1:0] action;
        logic [LED_BYTE_W-1:0]   echo_char;
        logic [LED_COUNT_W-1:0]  rubout_count;
    } t_key_result;

    typedef enum logic [2:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SELDOM,
        RX_PERIODIC,
        RX_LONG_STALL
    } t_rx_style;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the line state used to predict each result.
    bit [LED_MAX_COLUMNS-1:0] col_space    = '0;
    int                       line_len     = 0;
    bit                       session_over = 1'b0;
    logic [LED_CFG_W-1:0]     cfg_width    = LED_WIDTH_RESET;

    t_key_result pending_results [$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          rx_tick     = 0;
    t_rx_style   rx_style    = RX_ALWAYS;

    line_edit_discipline_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_result(input logic [LED_ACTION_W-1:0] act,
                                         input logic [LED_BYTE_W-1:0] ch,
                                         input int cnt);
        t_key_result r;
        r.action       = act;
        r.echo_char    = ch;
        r.rubout_count = LED_COUNT_W'(cnt);
        pending_results.push_back(r);
    endfunction

    // Applies one accepted keyboard byte to the local line state.
    function automatic void predict_key(input logic [7:0] c);
        int w;
        int n;
        logic [LED_ACTION_W-1:0] act;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > LED_MAX_COLUMNS) w = LED_MAX_COLUMNS;
        if (session_over) return;
        if (c == BYTE_EOF && line_len == 0) begin
            session_over = 1'b1;
            queue_result(ACT_EXIT, '0, 0);
        end else if (c == BYTE_ERASE) begin
            if (line_len > 0) begin
                line_len--;
                queue_result(ACT_RUBOUT, '0, 1);
            end
        end else if (c == BYTE_KILL) begin
            if (line_len > 0) queue_result(ACT_RUBOUT, '0, line_len);
            line_len = 0;
        end else if (c == BYTE_WERASE) begin
            // Trailing spaces go first, then the word before them.
            n = line_len;
            while (n > 0 && col_space[n-1]) n--;
            while (n > 0 && !col_space[n-1]) n--;
            if (line_len > n) queue_result(ACT_RUBOUT, '0, line_len - n);
            line_len = n;
        end else if (c >= BYTE_SPACE && c <= BYTE_LAST_PRINT) begin
            act = ACT_ECHO;
            if (line_len >= w) begin
                line_len = 0;
                act = ACT_WRAP;
            end
            col_space[line_len] = (c == BYTE_SPACE);
            line_len++;
            queue_result(act, c, 0);
        end else begin
            queue_result(ACT_BELL, '0, 0);
        end
    endfunction

    task automatic check_result(input logic [23:0] beat);
        t_key_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing pending", beat, 0);
        end else begin
            want = pending_results.pop_front();
            if (beat[2:0] != want.action)
                report_mismatch("action", beat[2:0], want.action);
            if (beat[10:3] != want.echo_char)
                report_mismatch("echo_char", beat[10:3], want.echo_char);
            if (beat[17:11] != want.rubout_count)
                report_mismatch("rubout_count", beat[17:11], want.rubout_count);
            if (beat[23:18] != '0)
                report_mismatch("padding", beat[23:18], 0);
        end
    endtask

    // Results are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) predict_key(s_axis_tdata);
        end
    end

    // Hang detection: counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("line_edit_discipline_top regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure, in one of five styles that switch at random.
    always @(negedge i_clk) begin
        if (rx_tick % 150 == 0) rx_style = t_rx_style'($urandom_range(0, 4));
        case (rx_style)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM:   m_axis_tready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: m_axis_tready <= ((rx_tick % 5) < 2);
            default:     m_axis_tready <= ((rx_tick % 40) >= 24);
        endcase
        rx_tick++;
    end

    // Sender works in bursts; between bursts tvalid drops for a random gap, which may be empty.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Sends one keyboard byte and returns on the falling edge after its beat.
    task automatic send_key(input logic [7:0] c);
        pace_sender();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    // Drains all pending results and lets a silent word erase finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_line_width(input logic [LED_CFG_W-1:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LINE_WIDTH, 2'b00};
        pwdata  <= {{(32-LED_CFG_W){1'b0}}, w};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_width = w;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Keeps random traffic from ending the session early.
    function automatic logic [7:0] avoid_exit(input logic [7:0] c);
        if (c == BYTE_EOF && line_len == 0) return BYTE_SPACE;
        return c;
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic test_edit_keys();
        foreach (EDIT_KEYS[i]) send_key(EDIT_KEYS[i]);
    endtask

    // Mostly typed words with edits in between, plus some raw noise.
    task automatic test_random_editing(input logic [LED_CFG_W-1:0] w, input bit set_width,
                                       input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        if (set_width) begin
            wait_idle();
            write_line_width(w);
        end
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = $urandom_range(1, 10);
                repeat (len) send_key(random_letter());
                sent += len;
                len = $urandom_range(0, 3);
                repeat (len) send_key(BYTE_SPACE);
                sent += len;
            end else begin
                if (pick < 58)      send_key(BYTE_ERASE);
                else if (pick < 62) send_key(BYTE_KILL);
                else if (pick < 74) send_key(BYTE_WERASE);
                else if (pick < 80) send_key(avoid_exit(BYTE_EOF));
                else if (pick < 88) send_key(BYTE_SPACE);
                else                send_key(avoid_exit(8'($urandom_range(0, 255))));
                sent++;
            end
        end
    endtask

    // Full 64 column lines: longest word erase, all-space erase and the wrap.
    task automatic test_full_line();
        wait_idle();
        write_line_width(7'(LED_MAX_COLUMNS));
        send_key(BYTE_KILL);
        repeat (LED_MAX_COLUMNS) send_key(random_letter());
        send_key(BYTE_WERASE);
        repeat (LED_MAX_COLUMNS) send_key(BYTE_SPACE);
        send_key(BYTE_WERASE);
        repeat (LED_MAX_COLUMNS + 1) send_key(random_letter());
        send_key(BYTE_KILL);
    endtask

    // Line width lowered below the current length: the next printable wraps.
    task automatic test_width_lowered();
        wait_idle();
        write_line_width(7'd50);
        repeat (20) send_key(random_letter());
        wait_idle();
        write_line_width(7'd5);
        send_key(random_letter());
        send_key(BYTE_SPACE);
        repeat (6) send_key(random_letter());
        send_key(BYTE_WERASE);
        send_key(BYTE_ERASE);
    endtask

    // End of session, after which every beat is dropped silently.
    task automatic test_exit();
        send_key(BYTE_KILL);
        send_key(BYTE_EOF);
        repeat (12) send_key(8'($urandom_range(0, 255)));
        send_key(BYTE_EOF);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edit_keys();
        test_random_editing(LED_WIDTH_RESET, 1'b0, 60);
        test_full_line();
        test_random_editing(7'd1, 1'b1, 55);
        test_random_editing(7'd0, 1'b1, 40);
        test_random_editing(7'd127, 1'b1, 60);
        test_random_editing(7'd65, 1'b1, 55);
        test_random_editing(7'd12, 1'b1, 55);
        test_random_editing(7'($urandom_range(1, 64)), 1'b1, 55);
        test_random_editing(7'd3, 1'b1, 45);
        test_width_lowered();
        test_random_editing(7'd64, 1'b1, 60);
        test_exit();

        wait_idle();
        if (mismatches == 0)
            $display("line_edit_discipline_top regression: pass");
        else
            $display("line_edit_discipline_top regression: fail");
        $finish;
    end

endmodule
